/* hdl/rtmphs_pkg.sv */
// shared types and constants for the rtmp handshake responder
// depends on nothing; imported by all modules but rtmphs_ram

package rtmphs_pkg;

  localparam int PACKET_BYTES = 1536;
  localparam int PKT_AW       = $clog2(PACKET_BYTES);
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
  localparam int ECHO_START   = 8;
  localparam int S2_CLR_LO    = 4;
  localparam int S2_CLR_HI    = 7;
  localparam byte unsigned VERSION_RESET = 8'd3;

  typedef enum logic [1:0] {
    PH_WAIT_C0C1 = 2'd0,
    PH_WAIT_C2   = 2'd1,
    PH_DONE      = 2'd2,
    PH_FAILED    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    SEG_S0 = 2'd0,
    SEG_S1 = 2'd1,
    SEG_S2 = 2'd2
  } tx_seg_t;

  typedef enum logic [1:0] {
    SRC_ZERO    = 2'd0,
    SRC_VERSION = 2'd1,
    SRC_LOCAL   = 2'd2,
    SRC_PEER    = 2'd3
  } tx_src_t;

  typedef enum logic {
    OP_RX = 1'b0,
    OP_TX = 1'b1
  } op_t;

  // one classified word handed from the front to the back
  typedef struct packed {
    logic              tx_valid;
    logic              tx_last;
    tx_src_t           src;
    logic [PKT_AW-1:0] addr;
    logic [7:0]        data;
    logic              cmp;
    logic              c2_end;
    phase_t            status;
    logic              consumed;
  } entry_t;

  // packet store write port driven by the front
  typedef struct packed {
    logic              we;
    logic [PKT_AW-1:0] addr;
    logic [7:0]        peer_data;
    logic [7:0]        local_data;
  } store_wr_t;

endpackage

/* hdl/rtmphs_ram.sv */
// generic single write port / single read port ram with registered read
// no dependencies

module rtmphs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/rtmphs_front.sv */
// front end: accepts words, runs the handshake counters, writes c1/s1 stores
// depends on rtmphs_pkg; feeds rtmphs_queue

module rtmphs_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic                       operation,
  input  logic [7:0]                 rx_byte,
  input  logic [7:0]                 random_byte,
  input  logic [7:0]                 version,
  output rtmphs_pkg::entry_t         entry,
  output rtmphs_pkg::store_wr_t      store_wr
);
  import rtmphs_pkg::*;

  localparam logic [PKT_AW-1:0] LAST_OFF = PKT_AW'(PACKET_BYTES - 1);

  phase_t            phase_r, phase_nxt;
  logic              c0_seen_r, c0_seen_nxt;
  logic [PKT_AW-1:0] rx_off_r, rx_off_nxt;
  logic              tx_pending_r, tx_pending_nxt;
  tx_seg_t           tx_seg_r, tx_seg_nxt;
  logic [PKT_AW-1:0] tx_off_r, tx_off_nxt;
  logic              rx_last, tx_off_last;

  assign rx_last     = (rx_off_r == LAST_OFF);
  assign tx_off_last = (tx_off_r == LAST_OFF);

  // next state
  always_comb begin
    phase_nxt      = phase_r;
    c0_seen_nxt    = c0_seen_r;
    rx_off_nxt     = rx_off_r;
    tx_pending_nxt = tx_pending_r;
    tx_seg_nxt     = tx_seg_r;
    tx_off_nxt     = tx_off_r;
    if (accept) begin
      if (op_t'(operation) == OP_TX) begin
        if (tx_pending_r) begin
          unique case (tx_seg_r)
            SEG_S0: begin
              tx_seg_nxt = SEG_S1;
              tx_off_nxt = '0;
            end
            SEG_S1: begin
              if (tx_off_last) begin
                tx_seg_nxt = SEG_S2;
                tx_off_nxt = '0;
              end else begin
                tx_off_nxt = tx_off_r + 1'b1;
              end
            end
            default: begin
              if (tx_off_last) begin
                tx_pending_nxt = 1'b0;
                tx_seg_nxt     = SEG_S0;
                tx_off_nxt     = '0;
              end else begin
                tx_off_nxt = tx_off_r + 1'b1;
              end
            end
          endcase
        end
      end else begin
        unique case (phase_r)
          PH_WAIT_C0C1: begin
            if (!c0_seen_r) begin
              if (rx_byte != version) begin
                phase_nxt = PH_FAILED;
              end else begin
                c0_seen_nxt = 1'b1;
              end
            end else if (rx_last) begin
              phase_nxt      = PH_WAIT_C2;
              rx_off_nxt     = '0;
              tx_pending_nxt = 1'b1;
              tx_seg_nxt     = SEG_S0;
              tx_off_nxt     = '0;
            end else begin
              rx_off_nxt = rx_off_r + 1'b1;
            end
          end
          PH_WAIT_C2: begin
            // done here means "c2 ended"; the back resolves done vs failed
            if (rx_last) begin
              phase_nxt  = PH_DONE;
              rx_off_nxt = '0;
            end else begin
              rx_off_nxt = rx_off_r + 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // classified word and store writes
  always_comb begin
    entry          = '0;
    entry.src      = SRC_ZERO;
    entry.status   = phase_nxt;
    store_wr       = '0;
    store_wr.addr  = rx_off_r;
    store_wr.peer_data  = rx_byte;
    store_wr.local_data = (rx_off_r < PKT_AW'(ECHO_START)) ? 8'd0 : random_byte;
    if (op_t'(operation) == OP_TX) begin
      if (tx_pending_r) begin
        entry.tx_valid = 1'b1;
        entry.addr     = tx_off_r;
        unique case (tx_seg_r)
          SEG_S0: begin
            entry.src  = SRC_VERSION;
            entry.data = version;
          end
          SEG_S1: entry.src = SRC_LOCAL;
          default: begin
            entry.tx_last = tx_off_last;
            if (tx_off_r >= PKT_AW'(S2_CLR_LO) && tx_off_r <= PKT_AW'(S2_CLR_HI)) begin
              entry.src = SRC_ZERO;
            end else begin
              entry.src = SRC_PEER;
            end
          end
        endcase
      end
    end else begin
      unique case (phase_r)
        PH_WAIT_C0C1: begin
          entry.consumed = 1'b1;
          store_wr.we    = accept & c0_seen_r;
        end
        PH_WAIT_C2: begin
          entry.consumed = 1'b1;
          entry.addr     = rx_off_r;
          entry.data     = rx_byte;
          entry.cmp      = (rx_off_r >= PKT_AW'(ECHO_START));
          entry.c2_end   = rx_last;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_WAIT_C0C1;
      c0_seen_r    <= 1'b0;
      rx_off_r     <= '0;
      tx_pending_r <= 1'b0;
      tx_seg_r     <= SEG_S0;
      tx_off_r     <= '0;
    end else begin
      phase_r      <= phase_nxt;
      c0_seen_r    <= c0_seen_nxt;
      rx_off_r     <= rx_off_nxt;
      tx_pending_r <= tx_pending_nxt;
      tx_seg_r     <= tx_seg_nxt;
      tx_off_r     <= tx_off_nxt;
    end
  end

endmodule

/* hdl/rtmphs_queue.sv */
// short flip-flop fifo of classified words between front and back
// depends on rtmphs_pkg

module rtmphs_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rtmphs_pkg::entry_t  push_entry,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output rtmphs_pkg::entry_t  head_entry
);
  import rtmphs_pkg::*;

  entry_t              slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]   count_r, count_nxt;

  assign full       = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

/* hdl/rtmphs_back.sv */
// back end: reads the packet stores, checks the c2 echo, drives the result word
// depends on rtmphs_pkg; store read data comes from two rtmphs_ram instances

module rtmphs_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              head_valid,
  input  rtmphs_pkg::entry_t                head_entry,
  output logic                              pop,
  output logic                              rd_en,
  output logic [rtmphs_pkg::PKT_AW-1:0]     rd_addr,
  input  logic [7:0]                        peer_rdata,
  input  logic [7:0]                        local_rdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [15:0]                       out_tdata,   // tx_byte, status, zero fill
  output logic [1:0]                        out_tuser,   // tx_valid, consumed
  output logic                              out_tlast    // tx_last
);
  import rtmphs_pkg::*;

  entry_t     a_entry_r;
  logic       a_valid_r;
  logic       o_valid_r;
  logic [7:0] o_byte_r;
  phase_t     o_status_r;
  logic       o_tx_valid_r, o_consumed_r, o_last_r;
  logic       mismatch_r, mismatch_nxt;
  phase_t     post_r, post_nxt;
  logic       advance;
  logic [7:0] byte_nxt;
  phase_t     status_nxt;
  logic       echo_bad;

  // stage a holds the word whose store read is in the ram output register
  assign advance = a_valid_r & (~o_valid_r | out_tready);
  assign pop     = head_valid & (~a_valid_r | advance);
  assign rd_en   = pop;
  assign rd_addr = head_entry.addr;

  always_comb begin
    unique case (a_entry_r.src)
      SRC_VERSION: byte_nxt = a_entry_r.data;
      SRC_LOCAL:   byte_nxt = local_rdata;
      SRC_PEER:    byte_nxt = peer_rdata;
      default:     byte_nxt = 8'd0;
    endcase
  end

  always_comb begin
    echo_bad     = a_entry_r.cmp & (a_entry_r.data != local_rdata);
    mismatch_nxt = mismatch_r | echo_bad;
    post_nxt     = post_r;
    status_nxt   = a_entry_r.status;
    if (a_entry_r.c2_end) begin
      status_nxt = mismatch_nxt ? PH_FAILED : PH_DONE;
      post_nxt   = status_nxt;
    end else if (a_entry_r.status == PH_DONE) begin
      // after c2 the outcome is sticky
      status_nxt = post_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_entry_r <= head_entry;
    end
    if (advance) begin
      o_byte_r     <= byte_nxt;
      o_status_r   <= status_nxt;
      o_tx_valid_r <= a_entry_r.tx_valid;
      o_consumed_r <= a_entry_r.consumed;
      o_last_r     <= a_entry_r.tx_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r  <= 1'b0;
      o_valid_r  <= 1'b0;
      mismatch_r <= 1'b0;
      post_r     <= PH_DONE;
    end else begin
      if (pop) begin
        a_valid_r <= 1'b1;
      end else if (advance) begin
        a_valid_r <= 1'b0;
      end
      if (advance) begin
        o_valid_r  <= 1'b1;
        mismatch_r <= mismatch_nxt;
        post_r     <= post_nxt;
      end else if (out_tready) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = o_valid_r;
  assign out_tdata  = {6'd0, o_status_r, o_byte_r};
  assign out_tuser  = {o_consumed_r, o_tx_valid_r};
  assign out_tlast  = o_last_r;

  a_last_is_tx: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid_r && o_last_r |-> o_tx_valid_r)
    else $error("last flag on a word that carries no handshake byte");

  a_tx_not_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid_r |-> !(o_tx_valid_r && o_consumed_r))
    else $error("transmit word marked as consumed");

  a_mismatch_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    mismatch_r |=> mismatch_r)
    else $error("echo mismatch flag cleared");

endmodule

/* hdl/rtmp_handshake_responder.sv */
// rtmp simple handshake responder, server side, one byte per word
// depends on rtmphs_pkg, rtmphs_front, rtmphs_queue, rtmphs_back, rtmphs_ram
//
// usage:
//   in_*  : one word per received byte (in_tuser 0) or transmit slot
//           (in_tuser 1); in_tdata carries rx_byte and random_byte
//   out_* : exactly one result word per input word, in order; out_tuser
//           flags tx_valid and consumed, out_tlast marks the last s2 byte,
//           out_tdata carries tx_byte and the handshake status
//   cfg_* : writes the version byte (expected c0, sent as s0); always ready,
//           write it only while no words are in flight
// an accepted word passes the queue, stage a and the output register;
// throughput is one word per cycle while out_tready is high, set by the
// single read port of each packet store and the one-word output register
// a 4-word queue separates the front from the store read and output stage,
// so in_tready only drops once the queue fills while out_tready is low
// reset (synchronous, rst_n low) returns to waiting for c0c1 with version 3;
// the packet stores are not cleared and need no clearing pass

module rtmp_handshake_responder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // rx_byte, random_byte
  input  logic        in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // tx_byte, status, zero fill
  output logic [1:0]  out_tuser,  // tx_valid, consumed
  output logic        out_tlast,  // tx_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // version_byte
);
  import rtmphs_pkg::*;

  logic              in_accept;
  logic              q_full;
  logic              q_pop;
  logic              q_head_valid;
  entry_t            front_entry;
  entry_t            q_head_entry;
  store_wr_t         store_wr;
  logic              rd_en;
  logic [PKT_AW-1:0] rd_addr;
  logic [7:0]        peer_rdata, local_rdata;
  logic [7:0]        version_r;

  assign cfg_ready = 1'b1;
  assign in_tready = ~q_full;
  assign in_accept = in_tvalid & ~q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r <= VERSION_RESET;
    end else if (cfg_valid) begin
      version_r <= cfg_data;
    end
  end

  rtmphs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .operation   (in_tuser),
    .rx_byte     (in_tdata[7:0]),
    .random_byte (in_tdata[15:8]),
    .version     (version_r),
    .entry       (front_entry),
    .store_wr    (store_wr)
  );

  rtmphs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_accept),
    .push_entry (front_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_entry (q_head_entry)
  );

  rtmphs_ram #(.WIDTH(8), .DEPTH(PACKET_BYTES)) u_peer_store (
    .clk   (clk),
    .we    (store_wr.we),
    .waddr (store_wr.addr),
    .wdata (store_wr.peer_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (peer_rdata)
  );

  rtmphs_ram #(.WIDTH(8), .DEPTH(PACKET_BYTES)) u_local_store (
    .clk   (clk),
    .we    (store_wr.we),
    .waddr (store_wr.addr),
    .wdata (store_wr.local_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (local_rdata)
  );

  rtmphs_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (q_head_valid),
    .head_entry  (q_head_entry),
    .pop         (q_pop),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .peer_rdata  (peer_rdata),
    .local_rdata (local_rdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

/* test/tb_rtmp_handshake_responder.sv */
// self-checking testbench for rtmp_handshake_responder: c0, right or wrong, and a first stretch of c1
// depends on rtmphs_pkg and the rtl of the block; random idling on both streams

`timescale 1ns / 100ps

module tb_rtmp_handshake_responder;
  import rtmphs_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_AT     = 600;
  localparam int HOLD_CYCLES = 400;
  localparam int CALM_FROM   = 150;
  localparam int CALM_TO     = 450;
  localparam int NOISE_WORDS = 400;
  localparam int C1_WORDS    = 400;

  typedef struct {
    op_t        op;
    logic [7:0] rx;
    logic [7:0] rnd;
  } hs_word_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_last;
    phase_t     status;
    logic       consumed;
  } hs_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // rx_byte, random_byte
  logic        in_tuser = OP_RX; // operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // tx_byte, status, zero fill
  logic [1:0]  out_tuser;       // tx_valid, consumed
  logic        out_tlast;       // tx_last
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;   // version_byte

  rtmp_handshake_responder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // handshake state as the block should hold it
  phase_t     hs_phase    = PH_WAIT_C0C1;
  int         hs_rx_pos   = 0;
  int         hs_tx_pos   = 0;
  bit         hs_tx_busy  = 1'b0;
  bit         hs_echo_bad = 1'b0;
  logic [7:0] hs_version  = VERSION_RESET;
  logic [7:0] hs_peer  [PACKET_BYTES];
  logic [7:0] hs_local [PACKET_BYTES];

  hs_word_t   pending_words[$];
  hs_result_t expected_results[$];

  int errors = 0;
  int n_in = 0;
  int n_out = 0;
  int n_tx_bytes = 0;
  int n_consumed = 0;
  int n_cfg = 0;
  int cyc = 0;
  int quiet = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  hs_result_t got, want;

  wire calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic hs_result_t handshake_step(op_t op, logic [7:0] rx, logic [7:0] rnd);
    hs_result_t r;
    int idx;
    int q;
    r = '0;
    if (op == OP_TX) begin
      if (hs_tx_busy) begin
        r.tx_valid = 1'b1;
        // s0, then s1, then s2 (c1 with bytes 4 to 7 cleared)
        if (hs_tx_pos == 0) begin
          r.tx_byte = hs_version;
        end else if (hs_tx_pos <= PACKET_BYTES) begin
          r.tx_byte = hs_local[hs_tx_pos - 1];
        end else begin
          q = hs_tx_pos - 1 - PACKET_BYTES;
          r.tx_byte = (q >= S2_CLR_LO && q <= S2_CLR_HI) ? 8'h00 : hs_peer[q];
        end
        if (hs_tx_pos >= 2 * PACKET_BYTES) begin
          r.tx_last  = 1'b1;
          hs_tx_busy = 1'b0;
          hs_tx_pos  = 0;
        end else begin
          hs_tx_pos++;
        end
      end
    end else if (hs_phase == PH_WAIT_C0C1) begin
      r.consumed = 1'b1;
      if (hs_rx_pos == 0) begin
        if (rx != hs_version) hs_phase = PH_FAILED;
        else hs_rx_pos = 1;
      end else begin
        idx = hs_rx_pos - 1;
        hs_peer[idx]  = rx;
        hs_local[idx] = (idx < ECHO_START) ? 8'h00 : rnd;
        if (idx == PACKET_BYTES - 1) begin
          hs_phase    = PH_WAIT_C2;
          hs_rx_pos   = 0;
          hs_tx_pos   = 0;
          hs_tx_busy  = 1'b1;
          hs_echo_bad = 1'b0;
        end else begin
          hs_rx_pos++;
        end
      end
    end else if (hs_phase == PH_WAIT_C2) begin
      idx = hs_rx_pos;
      r.consumed = 1'b1;
      if (idx >= ECHO_START && rx != hs_local[idx]) hs_echo_bad = 1'b1;
      if (idx == PACKET_BYTES - 1) begin
        hs_phase  = hs_echo_bad ? PH_FAILED : PH_DONE;
        hs_rx_pos = 0;
      end else begin
        hs_rx_pos++;
      end
    end
    r.status = hs_phase;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int seen, input int wanted);
    errors++;
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, field, seen, wanted);
  endtask

  function automatic void push_word(op_t op, logic [7:0] rx, logic [7:0] rnd);
    hs_word_t w;
    w.op  = op;
    w.rx  = rx;
    w.rnd = rnd;
    pending_words.insert(pending_words.size(), w);
  endfunction

  function automatic void push_noise(int count);
    for (int k = 0; k < count; k++)
      push_word($urandom_range(1) ? OP_TX : OP_RX, 8'($urandom_range(255)),
                8'($urandom_range(255)));
  endfunction

  // all words taken and answered, then a wait for the pipeline to empty
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_tvalid || expected_results.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_version(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid  <= 1'b0;
    hs_version = v;
    n_cfg++;
  endtask

  // sender: next word only once the current one is gone
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_words.size() != 0 && (calm || $urandom_range(99) >= 32)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {pending_words[0].rnd, pending_words[0].rx};
        in_tuser  <= pending_words[0].op;
        void'(pending_words.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, once, so the block backs up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_in >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= (hold_left == 0) && (calm || $urandom_range(99) >= 32);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        n_out <= n_out + 1;
        if (out_tuser[0]) n_tx_bytes <= n_tx_bytes + 1;
        if (out_tuser[1]) n_consumed <= n_consumed + 1;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected word", out_tdata, 0);
        end else begin
          want = expected_results.pop_front();
          got.tx_valid = out_tuser[0];
          got.consumed = out_tuser[1];
          got.tx_last  = out_tlast;
          got.tx_byte  = out_tdata[7:0];
          got.status   = phase_t'(out_tdata[9:8]);
          if (got.tx_valid !== want.tx_valid)
            report_mismatch("tx_valid", got.tx_valid, want.tx_valid);
          if (got.tx_byte !== want.tx_byte)
            report_mismatch("tx_byte", got.tx_byte, want.tx_byte);
          if (got.tx_last !== want.tx_last)
            report_mismatch("tx_last", got.tx_last, want.tx_last);
          if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
          if (got.consumed !== want.consumed)
            report_mismatch("consumed", got.consumed, want.consumed);
        end
      end
      if (in_tvalid && in_tready) begin
        expected_results.insert(expected_results.size(),
                                handshake_step(op_t'(in_tuser), in_tdata[7:0],
                                               in_tdata[15:8]));
        n_in <= n_in + 1;
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("timeout: nothing moved for %0d cycles", QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    logic [7:0] c0_version;
    int         outcome;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // c0 version: reset value, either extreme, or random
    case ($urandom_range(3))
      0: c0_version = VERSION_RESET;
      1: c0_version = 8'h00;
      2: c0_version = 8'hFF;
      default: c0_version = 8'($urandom_range(255));
    endcase
    if (c0_version != VERSION_RESET) write_version(c0_version);

    // 0: wrong version, otherwise a correct c0 and a first stretch of c1
    outcome = $urandom_range(7);

    // transmit slots before anything is pending
    push_word(OP_TX, 8'hFF, 8'hFF);
    push_word(OP_TX, 8'h00, 8'h00);
    push_word(OP_TX, 8'hA5, 8'h5A);

    if (outcome == 0) begin
      push_word(OP_RX, c0_version ^ 8'($urandom_range(255, 1)), 8'hFF);
      push_noise(NOISE_WORDS + NOISE_WORDS / 4);
      wait_drained();
    end else begin
      push_word(OP_RX, c0_version, 8'h00);
      // c1 with extremes in its first bytes, s1 zero area fed nonzero entropy
      for (int i = 0; i < C1_WORDS; i++) begin
        logic [7:0] rx;
        logic [7:0] rnd;
        rx  = (i < 8) ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom_range(255));
        rnd = (i < 8) ? ((i % 2) ? 8'h00 : 8'hFF) : 8'($urandom_range(255));
        if (i >= 8 && i < 12) rnd = (i % 2) ? 8'h00 : 8'hFF;
        if ($urandom_range(7) == 0)
          push_word(OP_TX, 8'($urandom_range(255)), 8'($urandom_range(255)));
        push_word(OP_RX, rx, rnd);
      end
      wait_drained();

      // version change in the middle of c1 must not disturb it
      write_version(~c0_version);
      push_noise(NOISE_WORDS / 4);
      wait_drained();
    end

    // late words: passed through after a failure, more c1 otherwise
    write_version(8'h00);
    push_noise(NOISE_WORDS / 2);
    wait_drained();
    write_version(8'hFF);
    push_noise(NOISE_WORDS / 4);
    wait_drained();

    repeat (10) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never seen", expected_results.size(), 0);

    $display("covered %0d words in, %0d out, %0d handshake bytes sent, %0d bytes consumed",
             n_in, n_out, n_tx_bytes, n_consumed);
    $display("final phase %s after %0d version writes", hs_phase.name(), n_cfg);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/rtmphs_pkg.sv
hdl/rtmphs_ram.sv
hdl/rtmphs_front.sv
hdl/rtmphs_queue.sv
hdl/rtmphs_back.sv
hdl/rtmp_handshake_responder.sv
test/tb_rtmp_handshake_responder.sv
